/* src/jcc_pkg.sv */
// Package for the joystick cursor controller: payload structs, register
// indexes, reset values and the move and phase codes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package jcc_pkg;

   // Sample width of both axes and of every threshold register.
   localparam int SAMPLE_BITS = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int COLUMN_BITS = 8;
   localparam int ROW_BITS = 3;
   localparam int ROW_DRIVE_BITS = 5;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_REST_LOW       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REST_HIGH      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTRE_VALUE   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFF_AXIS_LIMIT = 3'd5;

   // Cursor geometry.
   localparam logic [COLUMN_BITS-1:0] COLUMN_LEFT_EDGE  = 8'h80;
   localparam logic [COLUMN_BITS-1:0] COLUMN_RIGHT_EDGE = 8'h01;
   localparam logic [ROW_BITS-1:0]    ROW_TOP           = 3'd0;
   localparam logic [ROW_BITS-1:0]    ROW_BOTTOM        = 3'd4;

   typedef enum logic [2:0] {
      MOVE_NONE  = 3'd0,
      MOVE_LEFT  = 3'd1,
      MOVE_RIGHT = 3'd2,
      MOVE_UP    = 3'd3,
      MOVE_DOWN  = 3'd4
   } move_type;

   // Idle classifies the samples; hold ignores them for one item.
   typedef enum logic [1:0] {
      PH_IDLE = 2'b01,
      PH_HOLD = 2'b10
   } phase_type;

   typedef struct packed {
      sample_type horiz_sample;
      sample_type vert_sample;
   } req_type;

   typedef struct packed {
      logic [ROW_DRIVE_BITS-1:0] row_drive;
      logic [COLUMN_BITS-1:0]    column_pattern;
      logic [2:0]                move_taken;
   } rsp_type;

   typedef struct packed {
      sample_type rest_low;
      sample_type rest_high;
      sample_type low_threshold;
      sample_type high_threshold;
      sample_type centre_value;
      sample_type off_axis_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rest_low:       10'd500,
      rest_high:      10'd600,
      low_threshold:  10'd350,
      high_threshold: 10'd850,
      centre_value:   10'd512,
      off_axis_limit: 10'd250
   };

   // Next cursor state and the result for one item.
   typedef struct packed {
      phase_type              phase;
      logic [COLUMN_BITS-1:0] column;
      logic [ROW_BITS-1:0]    row;
      rsp_type                rsp;
   } step_type;

endpackage

`default_nettype wire

/* src/jcc_classify.sv */
// Combinational step of the cursor controller: classifies one sample pair
// and computes the next cursor state and the result item.
// Depends on jcc_pkg.
`default_nettype none

module jcc_classify (
   input  jcc_pkg::req_type                    req,
   input  jcc_pkg::cfg_type                    cfg,
   input  jcc_pkg::phase_type                  phase,
   input  logic [jcc_pkg::COLUMN_BITS-1:0]     column,
   input  logic [jcc_pkg::ROW_BITS-1:0]        row,
   output jcc_pkg::step_type                   step
);
   import jcc_pkg::*;

   move_type               move;
   logic [COLUMN_BITS-1:0] column_next;
   logic [ROW_BITS-1:0]    row_next;
   logic                   horiz_rest;
   logic                   vert_rest;
   logic                   horiz_near;
   logic                   vert_near;

   // True when the distance from centre is strictly below the limit.
   function automatic logic near_centre(input sample_type v, input sample_type c,
                                        input sample_type limit);
      sample_type distance;
      distance = (v >= c) ? sample_type'(v - c) : sample_type'(c - v);
      return distance < limit;
   endfunction

   assign horiz_rest = (req.horiz_sample > cfg.rest_low) && (req.horiz_sample < cfg.rest_high);
   assign vert_rest  = (req.vert_sample > cfg.rest_low) && (req.vert_sample < cfg.rest_high);
   assign horiz_near = near_centre(req.horiz_sample, cfg.centre_value, cfg.off_axis_limit);
   assign vert_near  = near_centre(req.vert_sample, cfg.centre_value, cfg.off_axis_limit);

   // Priority classification; only the idle phase looks at the samples.
   always_comb begin
      move = MOVE_NONE;
      if (phase == PH_IDLE) begin
         if (horiz_rest && vert_rest) begin
            move = MOVE_NONE;
         end else if ((req.horiz_sample < cfg.low_threshold) && vert_near) begin
            move = MOVE_LEFT;
         end else if ((req.horiz_sample > cfg.high_threshold) && vert_near) begin
            move = MOVE_RIGHT;
         end else if ((req.vert_sample > cfg.high_threshold) && horiz_near) begin
            move = MOVE_UP;
         end else if ((req.vert_sample < cfg.low_threshold) && horiz_near) begin
            move = MOVE_DOWN;
         end
      end
   end

   // Cursor update: the column rotates at the edges, the row holds at the
   // top and wraps from the bottom back to the top.
   always_comb begin
      column_next = column;
      row_next    = row;
      case (move)
         MOVE_LEFT: begin
            column_next = (column == COLUMN_LEFT_EDGE) ? COLUMN_RIGHT_EDGE
                                                       : {column[COLUMN_BITS-2:0], 1'b0};
         end
         MOVE_RIGHT: begin
            column_next = (column == COLUMN_RIGHT_EDGE) ? COLUMN_LEFT_EDGE
                                                        : {1'b0, column[COLUMN_BITS-1:1]};
         end
         MOVE_UP: begin
            if (row != ROW_TOP) begin
               row_next = row - 3'd1;
            end
         end
         MOVE_DOWN: begin
            row_next = (row >= ROW_BOTTOM) ? ROW_TOP : row + 3'd1;
         end
         default: begin
            column_next = column;
         end
      endcase
   end

   always_comb begin
      step.phase              = (move == MOVE_NONE) ? PH_IDLE : PH_HOLD;
      step.column             = column_next;
      step.row                = row_next;
      step.rsp.row_drive      = ~(5'b00001 << row_next);
      step.rsp.column_pattern = column_next;
      step.rsp.move_taken     = move;
   end

endmodule

`default_nettype wire

/* src/jcc_rsp_queue.sv */
// Two-entry result queue: holds finished items so that the input side keeps
// taking items while the output side is stalled, until both entries are full.
// Depends on jcc_pkg.
`default_nettype none

module jcc_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jcc_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jcc_pkg::rsp_type rsp_data
);
   import jcc_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       rd_ptr_ff;
   logic       wr_ptr_ff;
   logic       pop;
   rsp_type    slot_ff [2];

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Result storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/joystick_cursor_controller.sv */
// Top level of the joystick cursor controller: configuration registers,
// cursor state, the classify step and the result queue.
// Depends on jcc_pkg, jcc_classify and jcc_rsp_queue.
//
//   Channel   Ports                              Direction
//   request   req_valid, req_stall, req_data     in  (sample pair)
//   result    rsp_valid, rsp_stall, rsp_data     out (row drive, column, move)
//   config    csr_wr_en, csr_index, csr_wdata    in  (write only)
//
// One item per clock while req_stall is low; the result is written into the
// result queue when the item is taken. The classify step and the cursor update
// sit in one combinational stage ahead of a two-entry result queue.
// Reset is synchronous and puts the cursor at the top-left column, idle.
// req_stall rises only when both queue entries hold results not yet taken.
`default_nettype none

module joystick_cursor_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  jcc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output jcc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [jcc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [jcc_pkg::SAMPLE_BITS-1:0]     csr_wdata
);
   import jcc_pkg::*;

   cfg_type                cfg_ff;
   phase_type              phase_ff;
   logic [COLUMN_BITS-1:0] column_ff;
   logic [ROW_BITS-1:0]    row_ff;
   step_type               step;
   logic                   queue_full;
   logic                   req_accept;

   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_REST_LOW:       cfg_ff.rest_low       <= csr_wdata;
            REG_REST_HIGH:      cfg_ff.rest_high      <= csr_wdata;
            REG_LOW_THRESHOLD:  cfg_ff.low_threshold  <= csr_wdata;
            REG_HIGH_THRESHOLD: cfg_ff.high_threshold <= csr_wdata;
            REG_CENTRE_VALUE:   cfg_ff.centre_value   <= csr_wdata;
            REG_OFF_AXIS_LIMIT: cfg_ff.off_axis_limit <= csr_wdata;
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   jcc_classify u_classify (
      .req    (req_data),
      .cfg    (cfg_ff),
      .phase  (phase_ff),
      .column (column_ff),
      .row    (row_ff),
      .step   (step)
   );

   // Cursor state advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         column_ff <= COLUMN_LEFT_EDGE;
         row_ff    <= ROW_TOP;
      end else if (req_accept) begin
         phase_ff  <= step.phase;
         column_ff <= step.column;
         row_ff    <= step.row;
      end
   end

   jcc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (step.rsp),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // A hold item always returns the block to idle without moving the cursor.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_HOLD) |=>
         (phase_ff == PH_IDLE && $stable(column_ff) && $stable(row_ff)))
      else $error("hold item did not return to idle with the cursor held");

   // The cursor column stays one-hot.
   assert property (@(posedge clock) disable iff (reset) $onehot(column_ff))
      else $error("cursor column lost its one-hot form");

   // The row index never leaves the five visible rows.
   assert property (@(posedge clock) disable iff (reset) (row_ff <= ROW_BOTTOM))
      else $error("row index beyond the bottom row");

   // Cursor state only changes when an item is accepted.
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(column_ff) && $stable(row_ff) && $stable(phase_ff)))
      else $error("cursor state changed without an accepted item");
`endif

endmodule

`default_nettype wire

/* test/jcc_tb_pkg.sv */
// Scoreboard for the joystick cursor controller testbench: a cursor predictor
// with its own register copy, plus the queue of results still to arrive.
// Depends on jcc_pkg for the payload structs, register indexes and move codes.

package jcc_tb_pkg;

   import jcc_pkg::*;

   class cursor_scoreboard;

      cfg_type                cfg;
      logic                   holding;
      logic [COLUMN_BITS-1:0] column;
      logic [ROW_BITS-1:0]    row;
      rsp_type                cursor_due[$];
      int                     errors;

      // The predictor starts where the block does after reset.
      function new();
         cfg = CFG_RESET;
         holding = 1'b0;
         column = COLUMN_LEFT_EDGE;
         row = ROW_TOP;
         errors = 0;
      endfunction

      // Writes to indexes past the last register change nothing.
      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, sample_type value);
         case (index)
            REG_REST_LOW:       cfg.rest_low = value;
            REG_REST_HIGH:      cfg.rest_high = value;
            REG_LOW_THRESHOLD:  cfg.low_threshold = value;
            REG_HIGH_THRESHOLD: cfg.high_threshold = value;
            REG_CENTRE_VALUE:   cfg.centre_value = value;
            REG_OFF_AXIS_LIMIT: cfg.off_axis_limit = value;
            default: ;
         endcase
      endfunction

      function bit near_centre(sample_type s);
         sample_type distance;
         distance = (s >= cfg.centre_value) ? s - cfg.centre_value : cfg.centre_value - s;
         return distance < cfg.off_axis_limit;
      endfunction

      function bit in_rest(sample_type s);
         return s > cfg.rest_low && s < cfg.rest_high;
      endfunction

      // Advance the cursor by one accepted item and queue the result it causes.
      function void note_sample(req_type item);
         move_type   move;
         rsp_type    due;
         sample_type h;
         sample_type v;
         h = item.horiz_sample;
         v = item.vert_sample;
         move = MOVE_NONE;
         if (holding) begin
            // The item after a move is ignored and the cursor returns to idle.
            holding = 1'b0;
         end else begin
            if (in_rest(h) && in_rest(v))
               move = MOVE_NONE;
            else if (h < cfg.low_threshold && near_centre(v))
               move = MOVE_LEFT;
            else if (h > cfg.high_threshold && near_centre(v))
               move = MOVE_RIGHT;
            else if (v > cfg.high_threshold && near_centre(h))
               move = MOVE_UP;
            else if (v < cfg.low_threshold && near_centre(h))
               move = MOVE_DOWN;

            // Columns wrap at both edges, the top row holds and the bottom row wraps.
            case (move)
               MOVE_LEFT: begin
                  column = (column == COLUMN_LEFT_EDGE) ? COLUMN_RIGHT_EDGE : column << 1;
               end
               MOVE_RIGHT: begin
                  column = (column == COLUMN_RIGHT_EDGE) ? COLUMN_LEFT_EDGE : column >> 1;
               end
               MOVE_UP: begin
                  if (row != ROW_TOP)
                     row = row - 1'b1;
               end
               MOVE_DOWN: begin
                  row = (row == ROW_BOTTOM) ? ROW_TOP : row + 1'b1;
               end
               default: ;
            endcase
            holding = (move != MOVE_NONE);
         end
         due.row_drive = ~(5'd1 << row);
         due.column_pattern = column;
         due.move_taken = move;
         cursor_due.push_back(due);
      endfunction

      task report(string what);
         if (errors < 40)
            $display("mismatch: %s", what);
         errors++;
      endtask

      // Compare one accepted result against the oldest expected one.
      task check_result(rsp_type got);
         rsp_type due;
         if (cursor_due.size() == 0) begin
            report($sformatf("result %h arrived with no item outstanding", got));
            return;
         end
         due = cursor_due.pop_front();
         if (got.row_drive !== due.row_drive)
            report($sformatf("row_drive %h, predicted %h", got.row_drive, due.row_drive));
         if (got.column_pattern !== due.column_pattern)
            report($sformatf("column_pattern %h, predicted %h",
                             got.column_pattern, due.column_pattern));
         if (got.move_taken !== due.move_taken)
            report($sformatf("move_taken %0d, predicted %0d", got.move_taken, due.move_taken));
      endtask

   endclass

endpackage

/* test/tb.sv */
// Testbench top for the joystick cursor controller: drives sample pairs and
// register writes, and checks every result against the scoreboard predictor.
// Depends on jcc_pkg, jcc_tb_pkg and the joystick_cursor_controller RTL.

module tb;

   import jcc_pkg::*;
   import jcc_tb_pkg::*;

   // Indexes past the last register; writes to them must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED_LOW  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED_HIGH = 3'd7;
   localparam int LIMIT_CYCLES = 300000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   sample_type                csr_wdata = '0;

   cursor_scoreboard cursor_sb = new();
   int send_pct = 0;
   int recv_pct = 0;
   int hold_off = 0;

   // Directed sample pairs: edges of the columns, top and bottom rows,
   // ignored items after each move, off-axis pairs and rest band borders.
   int directed_pairs [24][2] = '{
      '{512, 512}, '{0, 512}, '{0, 512}, '{1023, 512}, '{1023, 1023}, '{1023, 512},
      '{0, 0}, '{0, 0}, '{512, 1023}, '{512, 512}, '{512, 0}, '{0, 0},
      '{512, 0}, '{1023, 1023}, '{512, 0}, '{0, 512}, '{512, 0}, '{512, 1023},
      '{512, 0}, '{1023, 0}, '{0, 512}, '{512, 512}, '{600, 500}, '{501, 599}
   };

   joystick_cursor_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic sample_type jitter(sample_type base, int spread);
      return sample_type'(int'(base) + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // A mix of moves around the current thresholds, rest pairs, near-register values, extremes and noise.
   function automatic req_type make_sample();
      req_type    item;
      cfg_type    c;
      int         span;
      sample_type regs [6];
      c = cursor_sb.cfg;
      span = (c.off_axis_limit > 0) ? int'(c.off_axis_limit) - 1 : 0;
      regs = '{c.rest_low, c.rest_high, c.low_threshold, c.high_threshold,
               c.centre_value, c.off_axis_limit};
      item.horiz_sample = sample_type'($urandom_range(0, 1023));
      item.vert_sample = sample_type'($urandom_range(0, 1023));
      case ($urandom_range(0, 9))
         2: begin
            item.horiz_sample = jitter(sample_type'((c.rest_low + c.rest_high) / 2), 60);
            item.vert_sample = jitter(sample_type'((c.rest_low + c.rest_high) / 2), 60);
         end
         3: begin
            item.horiz_sample = c.low_threshold - sample_type'($urandom_range(1, 60));
            item.vert_sample = jitter(c.centre_value, span);
         end
         4: begin
            item.horiz_sample = c.high_threshold + sample_type'($urandom_range(1, 60));
            item.vert_sample = jitter(c.centre_value, span);
         end
         5: begin
            item.vert_sample = c.high_threshold + sample_type'($urandom_range(1, 60));
            item.horiz_sample = jitter(c.centre_value, span);
         end
         6: begin
            item.vert_sample = c.low_threshold - sample_type'($urandom_range(1, 60));
            item.horiz_sample = jitter(c.centre_value, span);
         end
         7, 8: begin
            item.horiz_sample = jitter(regs[$urandom_range(0, 5)], 2);
            item.vert_sample = jitter(regs[$urandom_range(0, 5)], 2);
         end
         9: begin
            item.horiz_sample = $urandom_range(0, 1) ? '1 : '0;
            item.vert_sample = $urandom_range(0, 1) ? '1 : '0;
         end
         default: ;
      endcase
      return item;
   endfunction

   function automatic cfg_type random_config(bit ordered);
      cfg_type c;
      if (ordered) begin
         c.rest_low = sample_type'($urandom_range(380, 540));
         c.rest_high = c.rest_low + sample_type'($urandom_range(0, 120));
         c.low_threshold = sample_type'($urandom_range(1, 480));
         c.high_threshold = sample_type'($urandom_range(560, 1022));
         c.centre_value = sample_type'($urandom_range(400, 620));
         c.off_axis_limit = sample_type'($urandom_range(1, 500));
      end else begin
         c = cfg_type'({$urandom, $urandom});
      end
      return c;
   endfunction

   // One register write; the enable stays high for a following write.
   task automatic put_reg(logic [CSR_INDEX_BITS-1:0] index, sample_type value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      cursor_sb.write_reg(index, value);
   endtask

   task automatic load_config(cfg_type c, bit with_unused);
      put_reg(REG_REST_LOW, c.rest_low);
      put_reg(REG_REST_HIGH, c.rest_high);
      put_reg(REG_LOW_THRESHOLD, c.low_threshold);
      put_reg(REG_HIGH_THRESHOLD, c.high_threshold);
      put_reg(REG_CENTRE_VALUE, c.centre_value);
      put_reg(REG_OFF_AXIS_LIMIT, c.off_axis_limit);
      if (with_unused) begin
         put_reg(REG_UNUSED_LOW, sample_type'($urandom_range(0, 1023)));
         put_reg(REG_UNUSED_HIGH, sample_type'($urandom_range(0, 1023)));
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Offer one item, with random gaps before it, and wait until it is taken.
   task automatic send_item(req_type item);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (req_stall);
      cursor_sb.note_sample(item);
   endtask

   // Wait for every outstanding result, with a limit on the wait.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (cursor_sb.cursor_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(cfg_type c, bit with_unused, bit directed, int count);
      req_type item;
      load_config(c, with_unused);
      if (directed) begin
         for (int i = 0; i < 24; i++) begin
            item.horiz_sample = sample_type'(directed_pairs[i][0]);
            item.vert_sample = sample_type'(directed_pairs[i][1]);
            send_item(item);
         end
      end
      repeat (count) send_item(make_sample());
      drain();
   endtask

   // Result side: check accepted results and choose the next stall.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            cursor_sb.check_result(rsp_data);
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_pct);
         end
      end
   end

   // Main sequence: reset, then phases under several register settings.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_pct = 12;
      recv_pct = 68;
      run_phase(CFG_RESET, 1'b0, 1'b1, 300);
      // Nothing can move: no pair is near centre, and the rest band spans all but the end values.
      run_phase('{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd0}, 1'b0, 1'b0, 100);

      send_pct = 68;
      recv_pct = 12;
      // No rest band and loose thresholds, so nearly every idle item moves.
      run_phase('{10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd1023}, 1'b1, 1'b0, 150);
      run_phase(random_config(1'b1), 1'b0, 1'b0, 300);

      send_pct = 0;
      recv_pct = 0;
      run_phase(random_config(1'b0), 1'b0, 1'b0, 300);
      // Long result stall while items keep coming, so the block backs up.
      hold_off = 60;
      run_phase(random_config(1'b1), 1'b0, 1'b0, 300);
      run_phase(CFG_RESET, 1'b0, 1'b0, 300);

      if (cursor_sb.cursor_due.size() != 0)
         cursor_sb.report($sformatf("%0d results never arrived", cursor_sb.cursor_due.size()));
      if (cursor_sb.errors == 0) begin
         $display("joystick_cursor_controller verification clean");
      end else begin
         $display("joystick_cursor_controller verification failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #(12 * LIMIT_CYCLES);
      $display("joystick_cursor_controller verification failed");
      $finish;
   end

endmodule
